[sv/fstt_pkg.sv]
// ----------------------------------------------------------------------------
// fstt_pkg: shared types and constants
// Record and result formats, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package fstt_pkg;

    localparam int FLOW_ENTRIES_DEF   = 256;
    localparam int SOURCE_ENTRIES_DEF = 64;
    localparam logic [7:0] MIN_PREFIX_RESET = 8'd30;
    localparam logic [8:0] HALFOPEN_MAX = 9'd511;

    localparam logic CMD_TCP = 1'b0;
    localparam logic CMD_DNS = 1'b1;

    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_HALFOPEN = 2'd1;
    localparam logic [1:0] ST_OPEN     = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        syn_only;
        logic [7:0]  label_len;
    } in_item_t;

    typedef struct packed {
        logic [31:0] report_ip;
        logic [8:0]  halfopen_flows;
        logic [31:0] tunnel_total;
        logic        flow_full;
        logic        source_full;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FSCAN,
        S_FWAIT,
        S_SSCAN,
        S_SWAIT,
        S_UPDATE,
        S_READ,
        S_RWAIT,
        S_OUT
    } fsm_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // latch the input record
        logic fscan_start; // clear flow scan index
        logic fscan_step;  // compare one flow entry, advance
        logic sscan_start;
        logic sscan_step;
        logic update;      // apply the record's effects
        logic rd_capture;  // build the result
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic fscan_done;
        logic sscan_done;
    } dp_stat_t;

endpackage

[sv/fstt_datapath.sv]
// ----------------------------------------------------------------------------
// fstt_datapath: flow and source tables with scan hardware
// Walks each table one entry a cycle, then updates and forms the result.
// ----------------------------------------------------------------------------
module fstt_datapath import fstt_pkg::*; #(
    parameter int FLOW_ENTRIES   = FLOW_ENTRIES_DEF,
    parameter int SOURCE_ENTRIES = SOURCE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  item,
    input  logic [7:0] label_min,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_item_t result
);
    localparam int FW = $clog2(FLOW_ENTRIES);
    localparam int SW = $clog2(SOURCE_ENTRIES);
    localparam logic [FW:0] FLOW_CAP = (FW+1)'(FLOW_ENTRIES);
    localparam logic [SW:0] SRC_CAP  = (SW+1)'(SOURCE_ENTRIES);

    // Flow table: key memory plus status memory. Status is valid only below
    // the fill count, so no clearing pass is needed.
    logic [95:0] flow_key_mem [FLOW_ENTRIES];
    logic [1:0]  flow_st_mem  [FLOW_ENTRIES];
    logic [31:0] src_addr_mem [SOURCE_ENTRIES];
    logic [8:0]  src_hop_mem  [SOURCE_ENTRIES];
    logic [31:0] src_tun_mem  [SOURCE_ENTRIES];

    in_item_t    rec_reg;
    logic [FW:0] flow_fill_reg;
    logic [SW:0] src_fill_reg;
    logic [FW:0] fidx_reg;
    logic [SW:0] sidx_reg;
    logic        fhit_reg, shit_reg;
    logic [FW-1:0] fhit_idx_reg;
    logic [SW-1:0] shit_idx_reg;
    logic [95:0] fkey_rd_reg;
    logic [1:0]  fst_rd_reg;
    logic [31:0] saddr_rd_reg;
    logic        fvalid_reg, svalid_reg;  // read data in the pipe is live
    logic [FW-1:0] fpipe_idx_reg;
    logic [SW-1:0] spipe_idx_reg;
    logic [1:0]  hit_st_reg;
    logic [8:0]  hop_rd_reg;
    logic [31:0] tun_rd_reg;
    logic        rd_ok_reg;
    logic        ffull_reg, sfull_reg;
    out_item_t   result_reg;

    logic [95:0] key;
    logic        f_last, s_last;
    logic        fmatch, smatch;
    logic        flow_tab_full, src_tab_full;
    assign key = {rec_reg.src_ip, rec_reg.dst_ip, rec_reg.sport, rec_reg.dport};
    assign f_last = (fidx_reg >= flow_fill_reg);
    assign s_last = (sidx_reg >= src_fill_reg);
    assign flow_tab_full = (flow_fill_reg == FLOW_CAP);
    assign src_tab_full  = (src_fill_reg == SRC_CAP);
    assign fmatch = fvalid_reg && fst_rd_reg != ST_EMPTY && fkey_rd_reg == key;
    assign smatch = svalid_reg && saddr_rd_reg == rec_reg.src_ip;
    assign stat.fscan_done = f_last && !fvalid_reg;
    assign stat.sscan_done = s_last && !svalid_reg;

    // Update decisions.
    logic flow_new, flow_open, need_src, src_alloc, src_ok;
    logic [SW-1:0] src_idx;
    logic [31:0] tun_sum;
    logic [32:0] tun_add;
    always_comb begin
        flow_new  = rec_reg.cmd == CMD_TCP && !fhit_reg && !flow_tab_full;
        flow_open = rec_reg.cmd == CMD_TCP && fhit_reg && hit_st_reg == ST_HALFOPEN
                    && !rec_reg.syn_only;
        need_src  = (flow_new && rec_reg.syn_only) ||
                    (rec_reg.cmd == CMD_DNS && rec_reg.label_len >= label_min);
        src_alloc = need_src && !shit_reg && !src_tab_full;
        src_ok    = shit_reg || src_alloc;
        src_idx   = shit_reg ? shit_idx_reg : src_fill_reg[SW-1:0];
        tun_add   = {1'b0, tun_rd_reg} + {25'd0, rec_reg.label_len};
        tun_sum   = tun_add[32] ? 32'hFFFF_FFFF : tun_add[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_fill_reg <= '0;
            src_fill_reg  <= '0;
            fvalid_reg    <= 1'b0;
            svalid_reg    <= 1'b0;
        end else begin
            fvalid_reg <= cmd.fscan_step && !f_last && !fhit_reg;
            svalid_reg <= cmd.sscan_step && !s_last && !shit_reg;
            if (cmd.update) begin
                if (flow_new) flow_fill_reg <= flow_fill_reg + 1'b1;
                if (src_alloc) src_fill_reg <= src_fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) rec_reg <= item;
        if (cmd.fscan_start) begin
            fidx_reg <= '0;
            fhit_reg <= 1'b0;
        end else if (cmd.fscan_step) begin
            if (fmatch && !fhit_reg) begin
                fhit_reg     <= 1'b1;
                fhit_idx_reg <= fpipe_idx_reg;
                hit_st_reg   <= fst_rd_reg;
                fidx_reg     <= flow_fill_reg;
            end else if (!f_last && !fhit_reg) begin
                fidx_reg <= fidx_reg + 1'b1;
            end
        end
        if (cmd.sscan_start) begin
            sidx_reg <= '0;
            shit_reg <= 1'b0;
        end else if (cmd.sscan_step) begin
            if (smatch && !shit_reg) begin
                shit_reg     <= 1'b1;
                shit_idx_reg <= spipe_idx_reg;
                sidx_reg     <= src_fill_reg;
            end else if (!s_last && !shit_reg) begin
                sidx_reg <= sidx_reg + 1'b1;
            end
        end
        // Registered memory reads for the scans.
        fkey_rd_reg   <= flow_key_mem[fidx_reg[FW-1:0]];
        fst_rd_reg    <= flow_st_mem[fidx_reg[FW-1:0]];
        fpipe_idx_reg <= fidx_reg[FW-1:0];
        saddr_rd_reg  <= src_addr_mem[sidx_reg[SW-1:0]];
        spipe_idx_reg <= sidx_reg[SW-1:0];
        // Source counters of the hit entry, read once the scan settles.
        hop_rd_reg <= src_hop_mem[shit_idx_reg];
        tun_rd_reg <= src_tun_mem[shit_idx_reg];

        if (cmd.update) begin
            ffull_reg <= rec_reg.cmd == CMD_TCP && !fhit_reg && flow_tab_full;
            sfull_reg <= need_src && !src_ok;
            rd_ok_reg <= shit_reg || src_alloc;
            shit_idx_reg <= src_idx;
            if (flow_new) begin
                flow_key_mem[flow_fill_reg[FW-1:0]] <= key;
                flow_st_mem[flow_fill_reg[FW-1:0]]  <= rec_reg.syn_only ? ST_HALFOPEN : ST_OPEN;
            end
            if (flow_open) flow_st_mem[fhit_idx_reg] <= ST_OPEN;
            if (src_alloc) src_addr_mem[src_idx] <= rec_reg.src_ip;
            if (need_src && src_ok) begin
                if (rec_reg.cmd == CMD_DNS) begin
                    src_tun_mem[src_idx] <= shit_reg ? tun_sum : {24'd0, rec_reg.label_len};
                    if (src_alloc) src_hop_mem[src_idx] <= '0;
                end else begin
                    src_hop_mem[src_idx] <= shit_reg ?
                        (hop_rd_reg == HALFOPEN_MAX ? hop_rd_reg : hop_rd_reg + 1'b1) : 9'd1;
                    if (src_alloc) src_tun_mem[src_idx] <= '0;
                end
            end else if (flow_open && shit_reg && hop_rd_reg != 9'd0) begin
                src_hop_mem[src_idx] <= hop_rd_reg - 1'b1;
            end
        end
        if (cmd.rd_capture) begin
            result_reg.report_ip      <= rec_reg.src_ip;
            result_reg.halfopen_flows <= rd_ok_reg ? hop_rd_reg : 9'd0;
            result_reg.tunnel_total   <= rd_ok_reg ? tun_rd_reg : 32'd0;
            result_reg.flow_full      <= ffull_reg;
            result_reg.source_full    <= sfull_reg;
        end
    end

    assign result = result_reg;

endmodule

[sv/fstt_ctrl.sv]
// ----------------------------------------------------------------------------
// fstt_ctrl: record sequencer
// Steps a record through flow scan, source scan, update, readback, output.
// ----------------------------------------------------------------------------
module fstt_ctrl import fstt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT: begin
                cmd.fscan_start = 1'b1;
                cmd.sscan_start = 1'b1;
                state_next      = S_FSCAN;
            end
            S_FSCAN: begin
                cmd.fscan_step = 1'b1;
                if (stat.fscan_done) state_next = S_SSCAN;
            end
            S_SSCAN: begin
                cmd.sscan_step = 1'b1;
                if (stat.sscan_done) begin
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT: begin
                // Counter read of the matched source lands here.
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                // The updated counters are read back in this cycle.
                state_next = S_RWAIT;
            end
            S_RWAIT: begin
                cmd.rd_capture = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[sv/flow_scan_and_dns_tunnel_tracker.sv]
// ----------------------------------------------------------------------------
// flow_scan_and_dns_tunnel_tracker: half-open flow and DNS tunnel tracker
// Looks up TCP flows and per-source counters by linear scans of both tables.
// ----------------------------------------------------------------------------
// A record passes through the flow scan, the source scan, an update and a
// readback before its result is offered; a flow or source hit ends that
// scan early. A new record is taken only after the result transfer; the
// table scans visit one entry per cycle.
// Reset (aresetn low, synchronous) empties both tables and sets the label
// threshold to 30; no clearing pass is needed.
module flow_scan_and_dns_tunnel_tracker import fstt_pkg::*; #(
    parameter int FLOW_ENTRIES   = FLOW_ENTRIES_DEF,
    parameter int SOURCE_ENTRIES = SOURCE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    logic [7:0] label_min_reg;

    // The threshold register takes a write in any cycle.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            label_min_reg <= MIN_PREFIX_RESET;
        end else if (cfg_valid) begin
            label_min_reg <= cfg_data;
        end
    end

    fstt_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .stat, .cmd
    );

    fstt_datapath #(
        .FLOW_ENTRIES(FLOW_ENTRIES), .SOURCE_ENTRIES(SOURCE_ENTRIES)
    ) u_dp (
        .aclk, .aresetn, .item(s_data), .label_min(label_min_reg),
        .cmd, .stat, .result(m_data)
    );

    // A record is taken only while no result is pending.
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken during output");
    // A result stays offered until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // A record transfer is followed by a busy cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after transfer");

endmodule
